[design/bfha_pkg.sv]
package bfha_pkg;

   localparam int MAX_SEGMENTS_DEF = 64;
   localparam int HEADER_BYTES_DEF = 32;

   // request opcodes
   localparam logic [1:0] OP_ALLOC  = 2'd0;
   localparam logic [1:0] OP_FREE   = 2'd1;
   localparam logic [1:0] OP_RESIZE = 2'd2;

   // response status codes
   localparam logic [2:0] ST_OK       = 3'd0;
   localparam logic [2:0] ST_NO_SPACE = 3'd1;
   localparam logic [2:0] ST_ZERO     = 3'd2;
   localparam logic [2:0] ST_BAD_ADDR = 3'd3;
   localparam logic [2:0] ST_FULL     = 3'd4;

   typedef struct packed {
      logic [1:0]  op;
      logic [15:0] payload_address;
      logic [15:0] request_size;
   } req_type;

   typedef struct packed {
      logic [15:0] result_address;
      logic [2:0]  status;
      logic [15:0] used_bytes;
   } rsp_type;

endpackage

[design/bfha_seg_mem.sv]
module bfha_seg_mem import bfha_pkg::*; #(
   parameter int DEPTH = MAX_SEGMENTS_DEF,
   parameter int WIDTH = 8,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic             re,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (re) begin
         rdata <= mem[raddr];
      end
   end

endmodule

[design/bfha_free_pool.sv]
module bfha_free_pool import bfha_pkg::*; #(
   parameter int DEPTH = MAX_SEGMENTS_DEF,
   localparam int AW = $clog2(DEPTH),
   localparam int IW = AW + 1
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          pop,
   input  logic          push,
   input  logic [IW-1:0] push_idx,
   output logic          avail,
   output logic [IW-1:0] idx
);

   // released entries go on a stack, never-used entries come from a fill count
   logic [AW-1:0] stk [DEPTH];
   logic [IW-1:0] sp_ff, sp_in;
   logic [IW-1:0] fill_ff, fill_in;
   logic [AW-1:0] top_ff;
   logic [IW-1:0] sp_dec;

   assign avail = (sp_ff != '0) || (fill_ff != IW'(DEPTH));
   assign idx   = (sp_ff != '0) ? {1'b0, top_ff} : fill_ff;
   assign sp_dec = sp_in - IW'(1);

   always_comb begin
      sp_in   = sp_ff;
      fill_in = fill_ff;
      if (push) begin
         sp_in = sp_ff + IW'(1);
      end else if (pop) begin
         if (sp_ff != '0) begin
            sp_in = sp_ff - IW'(1);
         end else begin
            fill_in = fill_ff + IW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sp_ff   <= '0;
         fill_ff <= '0;
      end else begin
         sp_ff   <= sp_in;
         fill_ff <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         stk[sp_ff[AW-1:0]] <= push_idx[AW-1:0];
      end
   end

   // top of stack, with the pushed index forwarded
   always_ff @(posedge clock) begin
      if (push) begin
         top_ff <= push_idx[AW-1:0];
      end else if (sp_in != '0) begin
         top_ff <= stk[sp_dec[AW-1:0]];
      end
   end

endmodule

[design/best_fit_heap_allocator_unit.sv]
// response: strobe in the cycle after acceptance for requests that touch no segment, otherwise
// after a walk of the chain, one entry at a time (up to MAX_SEGMENTS, twice for a growing resize),
// and a read-modify-write on the table, the strobe state included
// throughput: one request at a time, busy stays high through the strobe, next one the cycle after
// reset: synchronous, empties the segment chain, heap top and used total, limit to 65535
// the response strobe lasts one cycle and cannot be stalled by the receiver
module best_fit_heap_allocator_unit import bfha_pkg::*; #(
   parameter int MAX_SEGMENTS = MAX_SEGMENTS_DEF,
   parameter int HEADER_BYTES = HEADER_BYTES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  req_type     req_item,
   output logic        rsp_valid,
   output rsp_type     rsp_item,
   input  logic        csr_we,
   input  logic [15:0] csr_wdata
);

   localparam int AW = $clog2(MAX_SEGMENTS);
   localparam int IW = AW + 1;
   localparam logic [IW-1:0] NIL = IW'(MAX_SEGMENTS);

   // one table entry: header offset, payload bytes, used mark and address-order links
   typedef struct packed {
      logic [15:0]   offset;
      logic [15:0]   size;
      logic          used;
      logic [IW-1:0] next;
      logic [IW-1:0] prev;
   } seg_type;

   localparam int SW = $bits(seg_type);

   // sequencer states
   localparam logic [4:0] S_IDLE     = 5'd0;
   localparam logic [4:0] S_WALK     = 5'd1;
   localparam logic [4:0] S_POST     = 5'd2;
   localparam logic [4:0] S_CV_START = 5'd3;
   localparam logic [4:0] S_CV_N     = 5'd4;
   localparam logic [4:0] S_CV_WT    = 5'd5;
   localparam logic [4:0] S_EXT      = 5'd6;
   localparam logic [4:0] S_FIX_RD   = 5'd7;
   localparam logic [4:0] S_FIX_WR   = 5'd8;
   localparam logic [4:0] S_AOK      = 5'd9;
   localparam logic [4:0] S_FR_RD    = 5'd10;
   localparam logic [4:0] S_FR_E     = 5'd11;
   localparam logic [4:0] S_FR_N     = 5'd12;
   localparam logic [4:0] S_FR_P     = 5'd13;
   localparam logic [4:0] S_FR_PM    = 5'd14;
   localparam logic [4:0] S_DONE     = 5'd15;

   localparam logic [16:0] HDR17 = 17'(HEADER_BYTES);
   localparam logic [15:0] HDR16 = 16'(HEADER_BYTES);

   // control state
   logic [4:0]    state_ff, state_in;
   logic [IW-1:0] head_ff, head_in;
   logic [IW-1:0] tail_ff, tail_in;
   logic [16:0]   top_ff, top_in;
   logic [15:0]   used_ff, used_in;
   logic [15:0]   limit_ff;

   // request and working registers
   logic [1:0]    op_ff, op_in;
   logic [15:0]   addr_ff, addr_in;
   logic [15:0]   rqsz_ff, rqsz_in;
   logic [IW-1:0] cur_ff, cur_in;
   logic          find_ff, find_in;       // walk looks up an address, else best fit
   logic          found_ff, found_in;
   seg_type       found_rec_ff, found_rec_in;
   logic          best_ok_ff, best_ok_in;
   logic [IW-1:0] best_ff, best_in;
   seg_type       best_rec_ff, best_rec_in;
   logic          resz_ff, resz_in;       // resize moving to a new segment
   logic [IW-1:0] e_idx_ff, e_idx_in;
   seg_type       erec_ff, erec_in;
   logic [IW-1:0] t_idx_ff, t_idx_in;
   seg_type       t_rec_ff, t_rec_in;
   logic          n_nil_ff, n_nil_in;
   logic          cv_alloc_ff, cv_alloc_in;
   logic [15:0]   old_ff, old_in;
   logic [IW-1:0] fix_idx_ff, fix_idx_in;
   logic [IW-1:0] fix_val_ff, fix_val_in;
   logic          fix_prev_ff, fix_prev_in;
   logic [4:0]    fix_ret_ff, fix_ret_in;
   logic [15:0]   res_ff, res_in;
   logic [2:0]    status_ff, status_in;

   // table memory and entry pool
   logic          mem_re, mem_we;
   logic [IW-1:0] mem_ridx, mem_widx;
   seg_type       mem_wrec, rrec;
   logic [SW-1:0] mem_rdata;
   logic          pool_pop, pool_push, pool_avail;
   logic [IW-1:0] pool_pidx, pool_idx;

   // arithmetic shared by the states
   logic [16:0]   req_plus_h;
   logic [17:0]   new_top;
   logic          addr_hit;
   logic [15:0]   rem16, off16;
   logic          accept;

   bfha_seg_mem #(
      .DEPTH (MAX_SEGMENTS),
      .WIDTH (SW)
   ) u_mem (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_widx[AW-1:0]),
      .wdata (mem_wrec),
      .re    (mem_re),
      .raddr (mem_ridx[AW-1:0]),
      .rdata (mem_rdata)
   );

   bfha_free_pool #(
      .DEPTH (MAX_SEGMENTS)
   ) u_pool (
      .clock    (clock),
      .reset    (reset),
      .pop      (pool_pop),
      .push     (pool_push),
      .push_idx (pool_pidx),
      .avail    (pool_avail),
      .idx      (pool_idx)
   );

   assign rrec       = seg_type'(mem_rdata);
   assign accept     = start && (state_ff == S_IDLE);
   assign busy       = (state_ff != S_IDLE);
   assign req_plus_h = {1'b0, rqsz_ff} + HDR17;
   assign new_top    = {1'b0, top_ff} + {1'b0, req_plus_h};
   assign addr_hit   = rrec.used && (({1'b0, rrec.offset} + HDR17) == {1'b0, addr_ff});
   // split arithmetic: remainder after the kept part and where it starts
   assign rem16      = t_rec_ff.size - rqsz_ff;
   assign off16      = t_rec_ff.offset + HDR16 + rqsz_ff;

   assign rsp_valid               = (state_ff == S_DONE);
   assign rsp_item.result_address = res_ff;
   assign rsp_item.status         = status_ff;
   assign rsp_item.used_bytes     = used_ff;

   always_comb begin
      state_in     = state_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      top_in       = top_ff;
      used_in      = used_ff;
      op_in        = op_ff;
      addr_in      = addr_ff;
      rqsz_in      = rqsz_ff;
      cur_in       = cur_ff;
      find_in      = find_ff;
      found_in     = found_ff;
      found_rec_in = found_rec_ff;
      best_ok_in   = best_ok_ff;
      best_in      = best_ff;
      best_rec_in  = best_rec_ff;
      resz_in      = resz_ff;
      e_idx_in     = e_idx_ff;
      erec_in      = erec_ff;
      t_idx_in     = t_idx_ff;
      t_rec_in     = t_rec_ff;
      n_nil_in     = n_nil_ff;
      cv_alloc_in  = cv_alloc_ff;
      old_in       = old_ff;
      fix_idx_in   = fix_idx_ff;
      fix_val_in   = fix_val_ff;
      fix_prev_in  = fix_prev_ff;
      fix_ret_in   = fix_ret_ff;
      res_in       = res_ff;
      status_in    = status_ff;
      mem_re       = 1'b0;
      mem_ridx     = '0;
      mem_we       = 1'b0;
      mem_widx     = '0;
      mem_wrec     = '0;
      pool_pop     = 1'b0;
      pool_push    = 1'b0;
      pool_pidx    = '0;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               op_in      = req_item.op;
               addr_in    = req_item.payload_address;
               rqsz_in    = req_item.request_size;
               res_in     = '0;
               status_in  = ST_OK;
               resz_in    = 1'b0;
               found_in   = 1'b0;
               best_ok_in = 1'b0;
               cur_in     = head_ff;
               state_in   = S_DONE;
               if (req_item.op == OP_FREE || req_item.op == OP_RESIZE) begin
                  find_in = (req_item.payload_address != '0);
               end else begin
                  find_in = 1'b0;
               end
               // decide whether the chain is walked at all
               if ((req_item.op == OP_FREE && req_item.payload_address != '0) ||
                   (req_item.op == OP_RESIZE && req_item.payload_address != '0)) begin
                  state_in = S_POST;
               end else if (req_item.op == OP_ALLOC || req_item.op == OP_RESIZE) begin
                  if (req_item.request_size == '0) begin
                     status_in = ST_ZERO;
                  end else begin
                     state_in = S_POST;
                  end
               end
               if (state_in == S_POST && head_ff != NIL) begin
                  mem_re   = 1'b1;
                  mem_ridx = head_ff;
                  state_in = S_WALK;
               end
            end
         end

         // one chain entry per cycle, next read addressed from the returned links
         S_WALK: begin
            if (find_ff) begin
               if (addr_hit) begin
                  found_in     = 1'b1;
                  found_rec_in = rrec;
                  e_idx_in     = cur_ff;
               end
            end else if (!rrec.used && rrec.size >= rqsz_ff &&
                         (!best_ok_ff || rrec.size < best_rec_ff.size)) begin
               best_ok_in  = 1'b1;
               best_in     = cur_ff;
               best_rec_in = rrec;
            end
            if ((find_ff && addr_hit) || rrec.next == NIL) begin
               state_in = S_POST;
            end else begin
               mem_re   = 1'b1;
               mem_ridx = rrec.next;
               cur_in   = rrec.next;
            end
         end

         S_POST: begin
            if (find_ff) begin
               if (!found_ff) begin
                  status_in = ST_BAD_ADDR;
                  state_in  = S_DONE;
               end else if (op_ff == OP_FREE) begin
                  state_in = S_FR_RD;
               end else if (rqsz_ff == '0) begin
                  status_in = ST_ZERO;
                  state_in  = S_DONE;
               end else if (found_rec_ff.size >= rqsz_ff) begin
                  // shrink in place
                  if ({1'b0, found_rec_ff.size} > req_plus_h) begin
                     t_idx_in    = e_idx_ff;
                     t_rec_in    = found_rec_ff;
                     old_in      = found_rec_ff.size;
                     cv_alloc_in = 1'b0;
                     state_in    = S_CV_START;
                  end else begin
                     res_in   = addr_ff;
                     state_in = S_DONE;
                  end
               end else begin
                  // grow: best-fit walk for a new segment, old one freed after
                  find_in    = 1'b0;
                  best_ok_in = 1'b0;
                  resz_in    = 1'b1;
                  cur_in     = head_ff;
                  mem_re     = 1'b1;
                  mem_ridx   = head_ff;
                  state_in   = S_WALK;
               end
            end else if (best_ok_ff) begin
               t_idx_in      = best_ff;
               t_rec_in      = best_rec_ff;
               t_rec_in.used = 1'b1;
               cv_alloc_in   = 1'b1;
               old_in        = best_rec_ff.size;
               if ({1'b0, best_rec_ff.size} > req_plus_h) begin
                  state_in = S_CV_START;
               end else begin
                  state_in = S_CV_WT;
               end
            end else begin
               state_in = S_EXT;
            end
         end

         S_CV_START: begin
            if (t_rec_ff.next != NIL) begin
               mem_re   = 1'b1;
               mem_ridx = t_rec_ff.next;
               n_nil_in = 1'b0;
            end else begin
               n_nil_in = 1'b1;
            end
            state_in = S_CV_N;
         end

         // remainder merges into a free follower, else becomes a segment if the pool has one
         S_CV_N: begin
            state_in = S_CV_WT;
            if (!n_nil_ff && !rrec.used) begin
               mem_we          = 1'b1;
               mem_widx        = t_rec_ff.next;
               mem_wrec        = rrec;
               mem_wrec.offset = off16;
               mem_wrec.size   = rrec.size + rem16;
               t_rec_in.size   = rqsz_ff;
            end else if (pool_avail) begin
               pool_pop        = 1'b1;
               mem_we          = 1'b1;
               mem_widx        = pool_idx;
               mem_wrec.offset = off16;
               mem_wrec.size   = rem16 - HDR16;
               mem_wrec.used   = 1'b0;
               mem_wrec.next   = t_rec_ff.next;
               mem_wrec.prev   = t_idx_ff;
               t_rec_in.next   = pool_idx;
               t_rec_in.size   = rqsz_ff;
               if (n_nil_ff) begin
                  tail_in = pool_idx;
               end else begin
                  fix_idx_in  = t_rec_ff.next;
                  fix_val_in  = pool_idx;
                  fix_prev_in = 1'b1;
                  fix_ret_in  = S_CV_WT;
                  state_in    = S_FIX_RD;
               end
            end
         end

         S_CV_WT: begin
            mem_we    = 1'b1;
            mem_widx  = t_idx_ff;
            mem_wrec  = t_rec_ff;
            status_in = ST_OK;
            if (cv_alloc_ff) begin
               used_in  = used_ff + t_rec_ff.size;
               res_in   = t_rec_ff.offset + HDR16;
               state_in = S_AOK;
            end else begin
               used_in  = used_ff - old_ff + t_rec_ff.size;
               res_in   = addr_ff;
               state_in = S_DONE;
            end
         end

         // append a segment at the heap top, if the limit and the pool allow
         S_EXT: begin
            if (new_top > {2'b0, limit_ff}) begin
               status_in = ST_NO_SPACE;
               state_in  = S_DONE;
            end else if (!pool_avail) begin
               status_in = ST_FULL;
               state_in  = S_DONE;
            end else begin
               pool_pop        = 1'b1;
               mem_we          = 1'b1;
               mem_widx        = pool_idx;
               mem_wrec.offset = top_ff[15:0];
               mem_wrec.size   = rqsz_ff;
               mem_wrec.used   = 1'b1;
               mem_wrec.next   = NIL;
               mem_wrec.prev   = tail_ff;
               tail_in         = pool_idx;
               top_in          = new_top[16:0];
               used_in         = used_ff + rqsz_ff;
               res_in          = top_ff[15:0] + HDR16;
               status_in       = ST_OK;
               if (tail_ff == NIL) begin
                  head_in  = pool_idx;
                  state_in = S_AOK;
               end else begin
                  fix_idx_in  = tail_ff;
                  fix_val_in  = pool_idx;
                  fix_prev_in = 1'b0;
                  fix_ret_in  = S_AOK;
                  state_in    = S_FIX_RD;
               end
            end
         end

         // link patch: read an entry, rewrite one of its links
         S_FIX_RD: begin
            mem_re   = 1'b1;
            mem_ridx = fix_idx_ff;
            state_in = S_FIX_WR;
         end

         S_FIX_WR: begin
            mem_we   = 1'b1;
            mem_widx = fix_idx_ff;
            mem_wrec = rrec;
            if (fix_prev_ff) begin
               mem_wrec.prev = fix_val_ff;
            end else begin
               mem_wrec.next = fix_val_ff;
            end
            state_in = fix_ret_ff;
         end

         S_AOK: begin
            state_in = resz_ff ? S_FR_RD : S_DONE;
         end

         S_FR_RD: begin
            mem_re   = 1'b1;
            mem_ridx = e_idx_ff;
            state_in = S_FR_E;
         end

         S_FR_E: begin
            erec_in      = rrec;
            erec_in.used = 1'b0;
            used_in      = used_ff - rrec.size;
            if (rrec.next != NIL) begin
               mem_re   = 1'b1;
               mem_ridx = rrec.next;
               state_in = S_FR_N;
            end else begin
               state_in = S_FR_P;
            end
         end

         // absorb a free follower
         S_FR_N: begin
            state_in = S_FR_P;
            if (!rrec.used) begin
               erec_in.size = erec_ff.size + HDR16 + rrec.size;
               erec_in.next = rrec.next;
               pool_push    = 1'b1;
               pool_pidx    = erec_ff.next;
               if (rrec.next != NIL) begin
                  fix_idx_in  = rrec.next;
                  fix_val_in  = e_idx_ff;
                  fix_prev_in = 1'b1;
                  fix_ret_in  = S_FR_P;
                  state_in    = S_FIX_RD;
               end else begin
                  tail_in = e_idx_ff;
               end
            end
         end

         S_FR_P: begin
            if (erec_ff.prev != NIL) begin
               mem_re   = 1'b1;
               mem_ridx = erec_ff.prev;
               state_in = S_FR_PM;
            end else begin
               mem_we   = 1'b1;
               mem_widx = e_idx_ff;
               mem_wrec = erec_ff;
               state_in = S_DONE;
            end
         end

         // fold into a free predecessor, else write the freed entry back
         S_FR_PM: begin
            state_in = S_DONE;
            mem_we   = 1'b1;
            if (!rrec.used) begin
               mem_widx      = erec_ff.prev;
               mem_wrec      = rrec;
               mem_wrec.size = rrec.size + HDR16 + erec_ff.size;
               mem_wrec.next = erec_ff.next;
               pool_push     = 1'b1;
               pool_pidx     = e_idx_ff;
               if (erec_ff.next != NIL) begin
                  fix_idx_in  = erec_ff.next;
                  fix_val_in  = erec_ff.prev;
                  fix_prev_in = 1'b1;
                  fix_ret_in  = S_DONE;
                  state_in    = S_FIX_RD;
               end else begin
                  tail_in = erec_ff.prev;
               end
            end else begin
               mem_widx = e_idx_ff;
               mem_wrec = erec_ff;
            end
         end

         S_DONE: begin
            state_in = S_IDLE;
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         head_ff  <= NIL;
         tail_ff  <= NIL;
         top_ff   <= '0;
         used_ff  <= '0;
         limit_ff <= 16'hFFFF;
      end else begin
         state_ff <= state_in;
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         top_ff   <= top_in;
         used_ff  <= used_in;
         if (csr_we) begin
            limit_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      addr_ff      <= addr_in;
      rqsz_ff      <= rqsz_in;
      cur_ff       <= cur_in;
      find_ff      <= find_in;
      found_ff     <= found_in;
      found_rec_ff <= found_rec_in;
      best_ok_ff   <= best_ok_in;
      best_ff      <= best_in;
      best_rec_ff  <= best_rec_in;
      resz_ff      <= resz_in;
      e_idx_ff     <= e_idx_in;
      erec_ff      <= erec_in;
      t_idx_ff     <= t_idx_in;
      t_rec_ff     <= t_rec_in;
      n_nil_ff     <= n_nil_in;
      cv_alloc_ff  <= cv_alloc_in;
      old_ff       <= old_in;
      fix_idx_ff   <= fix_idx_in;
      fix_val_ff   <= fix_val_in;
      fix_prev_ff  <= fix_prev_in;
      fix_ret_ff   <= fix_ret_in;
      res_ff       <= res_in;
      status_ff    <= status_in;
   end

endmodule
